// ===== hdl/budget_cap_search_top_macros.svh =====
// assertion macros for the budget cap search block
// included by the top level; defining ASSERT_OFF leaves the bodies empty
`ifndef BUDGET_CAP_SEARCH_TOP_MACROS_SVH
`define BUDGET_CAP_SEARCH_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define BCS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BCS_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   `BCS_ASSERT(lbl, clk, rst, !(cond), msg)
`else
`define BCS_ASSERT(lbl, clk, rst, prop, msg)
`define BCS_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

// ===== hdl/bcs_pkg.sv =====
// shared types, constants and the microcode table of the budget cap search
// used by the sequencer, the datapath and the top level
package bcs_pkg;

   // result cap and budget width
   localparam int CAP_W = 48;
   localparam int STEP_W = 3;

   typedef logic [STEP_W-1:0] step_type;

   // microcode step addresses
   localparam step_type STEP_LOAD   = 3'd0;
   localparam step_type STEP_CHECK  = 3'd1;
   localparam step_type STEP_PROBE  = 3'd2;
   localparam step_type STEP_SCAN   = 3'd3;
   localparam step_type STEP_DECIDE = 3'd4;
   localparam step_type STEP_EMIT   = 3'd5;

   // jump conditions
   typedef enum logic [2:0] {
      COND_LAST        = 3'd0,
      COND_TOTAL_FITS  = 3'd1,
      COND_SEARCH_DONE = 3'd2,
      COND_SCAN_DONE   = 3'd3,
      COND_PROCEED     = 3'd4,
      COND_OUT_FREE    = 3'd5
   } cond_type;

   // one control word
   typedef struct packed {
      logic     accept_en;
      logic     init_en;
      logic     probe_en;
      logic     scan_en;
      logic     decide_en;
      logic     emit_en;
      cond_type cond;
      step_type target;
      logic     hold;
   } ctrl_type;

   // datapath flags seen by the sequencer
   typedef struct packed {
      logic last_accept;
      logic total_fits;
      logic search_done;
      logic scan_done;
      logic proceed;
      logic out_free;
   } status_type;

   // microcode rom: taken jump goes to target, else hold or fall through
   function automatic ctrl_type ucode_rom(step_type step);
      ctrl_type w;
      w = '0;
      unique case (step)
         STEP_LOAD: begin
            w.accept_en = 1'b1;
            w.cond      = COND_LAST;
            w.target    = STEP_CHECK;
            w.hold      = 1'b1;
         end
         STEP_CHECK: begin
            w.init_en = 1'b1;
            w.cond    = COND_TOTAL_FITS;
            w.target  = STEP_EMIT;
         end
         STEP_PROBE: begin
            w.probe_en = 1'b1;
            w.cond     = COND_SEARCH_DONE;
            w.target   = STEP_EMIT;
         end
         STEP_SCAN: begin
            w.scan_en = 1'b1;
            w.cond    = COND_SCAN_DONE;
            w.target  = STEP_DECIDE;
            w.hold    = 1'b1;
         end
         STEP_DECIDE: begin
            w.decide_en = 1'b1;
            w.cond      = COND_PROCEED;
            w.target    = STEP_PROBE;
         end
         STEP_EMIT: begin
            w.emit_en = 1'b1;
            w.cond    = COND_OUT_FREE;
            w.target  = STEP_LOAD;
            w.hold    = 1'b1;
         end
         default: begin
            w.cond   = COND_LAST;
            w.target = STEP_LOAD;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== hdl/budget_cap_search_top.sv =====
// loading: demand words are stored as they are accepted; after the last word a check step,
// then up to 49 probes, each walking the n stored demands with one store read
// per cycle in the capped-sum walk, and a closing probe step, then the emit step
// loads the result register; an unlimited result goes from the check step to the emit step
// synchronous active-high reset clears the control state and the budget;
// the demand store is not cleared and needs no clearing pass
`include "budget_cap_search_top_macros.svh"
module budget_cap_search_top #(
   parameter int MAX_ITEMS    = 1024,
   parameter int DEMAND_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [((DEMAND_WIDTH+7)/8)*8-1:0] req_tdata,  // demand
   input  logic                              req_tlast,  // last_item
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [bcs_pkg::CAP_W-1:0]         rsp_tdata,  // cap
   output logic [1:0]                        rsp_tuser,  // unlimited, overflow
   input  logic                              csr_we,
   input  logic [bcs_pkg::CAP_W-1:0]         csr_wdata   // budget
);

   import bcs_pkg::*;

   ctrl_type   ctrl;
   status_type status;

   // control program
   bcs_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // store and arithmetic
   bcs_datapath #(
      .MAX_ITEMS    (MAX_ITEMS),
      .DEMAND_WIDTH (DEMAND_WIDTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .status     (status),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // checks
   `BCS_ASSERT(a_last_stops_input, clock, reset, (req_tvalid && req_tready && req_tlast) |=> !req_tready, "word accepted right after the last word of a set")
   `BCS_ASSERT(a_unlimited_zero_cap, clock, reset, (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == '0), "unlimited result with a nonzero cap")
   `BCS_ASSERT(a_result_from_emit, clock, reset, $rose(rsp_tvalid) |-> $past(ctrl.emit_en), "result raised outside the emit step")

endmodule

// ===== hdl/bcs_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module bcs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/bcs_sequencer.sv =====
// microcode sequencer: step counter, control rom and conditional jumps
// depends on bcs_pkg
module bcs_sequencer (
   input  logic               clock,
   input  logic               reset,
   input  bcs_pkg::status_type status,
   output bcs_pkg::ctrl_type   ctrl
);

   import bcs_pkg::*;

   step_type step_ff;
   step_type step_in;
   logic     taken;

   assign ctrl = ucode_rom(step_ff);

   // condition select
   always_comb begin
      unique case (ctrl.cond)
         COND_LAST:        taken = status.last_accept;
         COND_TOTAL_FITS:  taken = status.total_fits;
         COND_SEARCH_DONE: taken = status.search_done;
         COND_SCAN_DONE:   taken = status.scan_done;
         COND_PROCEED:     taken = status.proceed;
         COND_OUT_FREE:    taken = status.out_free;
         default:          taken = 1'b0;
      endcase
   end

   // next step
   always_comb begin
      if (taken) begin
         step_in = ctrl.target;
      end else if (ctrl.hold) begin
         step_in = step_ff;
      end else begin
         step_in = step_ff + step_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_LOAD;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

// ===== hdl/bcs_datapath.sv =====
// datapath: demand store, running total, search bounds, capped-sum walk
// depends on bcs_pkg and bcs_ram
module bcs_datapath #(
   parameter int MAX_ITEMS    = 1024,
   parameter int DEMAND_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  bcs_pkg::ctrl_type                 ctrl,
   output bcs_pkg::status_type               status,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [((DEMAND_WIDTH+7)/8)*8-1:0] req_tdata,
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [bcs_pkg::CAP_W-1:0]         rsp_tdata,
   output logic [1:0]                        rsp_tuser,
   input  logic                              csr_we,
   input  logic [bcs_pkg::CAP_W-1:0]         csr_wdata
);

   import bcs_pkg::*;

   localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
   localparam int ADDR_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int TOT_W  = DEMAND_WIDTH + CNT_W;
   localparam int CMP_W  = (TOT_W > CAP_W) ? TOT_W : CAP_W;

   logic [CAP_W-1:0]        budget_ff, budget_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [TOT_W-1:0]        total_ff, total_in;
   logic                    too_many_ff, too_many_in;
   logic [CAP_W:0]          low_ff, low_in;
   logic [CAP_W-1:0]        high_ff, high_in;
   logic [CAP_W-1:0]        best_ff, best_in;
   logic [CAP_W-1:0]        mid_ff, mid_in;
   logic [TOT_W-1:0]        sum_ff, sum_in;
   logic [CNT_W-1:0]        idx_ff, idx_in;
   logic                    rdv_ff, rdv_in;
   logic                    unl_ff, unl_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CAP_W-1:0]        rsp_cap_ff, rsp_cap_in;
   logic                    rsp_unl_ff, rsp_unl_in;
   logic                    rsp_ovf_ff, rsp_ovf_in;

   logic [DEMAND_WIDTH-1:0] demand;
   logic [DEMAND_WIDTH-1:0] rd_data;
   logic [DEMAND_WIDTH-1:0] capped;
   logic [CAP_W-1:0]        low_cut;
   logic                    accept;
   logic                    room;
   logic                    issue;
   logic                    total_fits;
   logic                    sum_fits;
   logic                    out_free;
   logic                    emit_fire;

   assign demand     = req_tdata[DEMAND_WIDTH-1:0];
   assign req_tready = ctrl.accept_en;
   assign accept     = req_tvalid & ctrl.accept_en;
   assign room       = count_ff < CNT_W'(MAX_ITEMS);
   assign issue      = idx_ff < count_ff;
   assign low_cut    = low_ff[CAP_W-1:0];
   assign total_fits = CMP_W'(total_ff) <= CMP_W'(budget_ff);
   assign sum_fits   = CMP_W'(sum_ff) <= CMP_W'(budget_ff);
   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign emit_fire  = ctrl.emit_en & out_free;

   // demand store
   bcs_ram #(
      .WIDTH (DEMAND_WIDTH),
      .DEPTH (MAX_ITEMS)
   ) u_store (
      .clock   (clock),
      .wr_en   (accept & room),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (demand),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // min of stored demand and probe cap, fits the demand width
   assign capped = (CAP_W'(rd_data) < mid_ff) ? rd_data : mid_ff[DEMAND_WIDTH-1:0];

   // flags for the sequencer
   always_comb begin
      status.last_accept = accept & req_tlast;
      status.total_fits  = total_fits;
      status.search_done = low_ff > {1'b0, high_ff};
      status.scan_done   = (idx_ff == count_ff) & ~rdv_ff;
      status.proceed     = sum_fits | (mid_ff != '0);
      status.out_free    = out_free;
   end

   // config register
   assign budget_in = csr_we ? csr_wdata : budget_ff;

   // set collection: count, total, overflow flag
   always_comb begin
      count_in    = count_ff;
      total_in    = total_ff;
      too_many_in = too_many_ff;
      if (accept) begin
         if (room) begin
            count_in = count_ff + CNT_W'(1);
            total_in = total_ff + TOT_W'(demand);
         end else begin
            too_many_in = 1'b1;
         end
      end
      if (emit_fire) begin
         count_in    = '0;
         total_in    = '0;
         too_many_in = 1'b0;
      end
   end

   // search bounds and best cap
   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      best_in = best_ff;
      mid_in  = mid_ff;
      unl_in  = unl_ff;
      if (ctrl.init_en) begin
         low_in  = '0;
         high_in = budget_ff;
         best_in = '0;
         unl_in  = total_fits;
      end
      if (ctrl.probe_en) begin
         mid_in = low_cut + ((high_ff - low_cut) >> 1);
      end
      if (ctrl.decide_en) begin
         if (sum_fits) begin
            best_in = mid_ff;
            low_in  = {1'b0, mid_ff} + (CAP_W+1)'(1);
         end else begin
            high_in = mid_ff - CAP_W'(1);
         end
      end
   end

   // capped-sum walk over the store, one entry a cycle
   always_comb begin
      idx_in = idx_ff;
      sum_in = sum_ff;
      rdv_in = 1'b0;
      if (ctrl.probe_en) begin
         idx_in = '0;
         sum_in = '0;
      end
      if (ctrl.scan_en) begin
         if (issue) begin
            idx_in = idx_ff + CNT_W'(1);
         end
         rdv_in = issue;
         if (rdv_ff) begin
            sum_in = sum_ff + TOT_W'(capped);
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_cap_in   = rsp_cap_ff;
      rsp_unl_in   = rsp_unl_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
         rsp_cap_in   = unl_ff ? '0 : best_ff;
         rsp_unl_in   = unl_ff;
         rsp_ovf_in   = too_many_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff    <= '0;
         count_ff     <= '0;
         total_ff     <= '0;
         too_many_ff  <= 1'b0;
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         budget_ff    <= budget_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         too_many_ff  <= too_many_in;
         rdv_ff       <= rdv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      low_ff     <= low_in;
      high_ff    <= high_in;
      best_ff    <= best_in;
      mid_ff     <= mid_in;
      sum_ff     <= sum_in;
      idx_ff     <= idx_in;
      unl_ff     <= unl_in;
      rsp_cap_ff <= rsp_cap_in;
      rsp_unl_ff <= rsp_unl_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_cap_ff;
   assign rsp_tuser  = {rsp_ovf_ff, rsp_unl_ff};

endmodule

// ===== bench/budget_cap_search_checker.sv =====
`timescale 1ns / 1ps
// checker for the budget cap search: watches the demand, result and csr channels,
// keeps its own copy of the stored set and budget, and compares every result word
// depends on bcs_pkg for the cap width
module budget_cap_search_checker #(
   parameter int MAX_ITEMS    = 1024,
   parameter int DEMAND_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [((DEMAND_WIDTH+7)/8)*8-1:0] req_tdata,   // demand
   input  logic                              req_tlast,   // last_item
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [bcs_pkg::CAP_W-1:0]         rsp_tdata,   // cap
   input  logic [1:0]                        rsp_tuser,   // unlimited, overflow
   input  logic                              csr_we,
   input  logic [bcs_pkg::CAP_W-1:0]         csr_wdata,   // budget
   output int unsigned                       mismatches,
   output int unsigned                       awaiting
);
   import bcs_pkg::*;

   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [CAP_W-1:0] cap;
      logic             unlimited;
      logic             overflow;
   } cap_result_type;

   // mirror of the block state
   logic [DEMAND_WIDTH-1:0] demand_mem [MAX_ITEMS];
   int unsigned             held_count = 0;
   logic [63:0]             held_total = '0;
   logic                    store_full_hit = 1'b0;
   logic [CAP_W-1:0]        budget_q = '0;
   cap_result_type          cap_results_q [$];
   int unsigned             fail_count = 0;

   // sum of every stored demand clipped at cap
   function automatic logic [63:0] capped_sum(input logic [63:0] cap);
      logic [63:0] acc;
      acc = '0;
      for (int unsigned i = 0; i < held_count; i++)
         acc += (demand_mem[i] < cap) ? 64'(demand_mem[i]) : cap;
      return acc;
   endfunction

   // largest cap in 0..budget whose clipped sum still fits
   function automatic logic [CAP_W-1:0] largest_cap();
      logic [63:0] lo, hi, mid, best;
      lo   = '0;
      hi   = 64'(budget_q);
      best = '0;
      while (lo <= hi) begin
         mid = lo + (hi - lo) / 2;
         if (capped_sum(mid) <= 64'(budget_q)) begin
            best = mid;
            lo   = mid + 1;
         end else begin
            if (mid == 0) break;
            hi = mid - 1;
         end
      end
      return best[CAP_W-1:0];
   endfunction

   task automatic note_failure(input string why, input cap_result_type want,
                               input cap_result_type got);
      fail_count++;
      if (fail_count <= MAX_REPORTS)
         $display("%0t checker %s: want cap=%h unl=%b ovf=%b, got cap=%h unl=%b ovf=%b",
                  $realtime, why, want.cap, want.unlimited, want.overflow,
                  got.cap, got.unlimited, got.overflow);
   endtask

   always @(posedge clock) begin
      cap_result_type          got;
      cap_result_type          want;
      logic [DEMAND_WIDTH-1:0] d;
      if (reset) begin
         held_count     = 0;
         held_total     = '0;
         store_full_hit = 1'b0;
         budget_q       = '0;
         cap_results_q.delete();
      end else begin
         // result word against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got.cap       = rsp_tdata;
            got.unlimited = rsp_tuser[0];
            got.overflow  = rsp_tuser[1];
            if (cap_results_q.size() == 0) begin
               note_failure("result word with nothing pending", '0, got);
            end else begin
               want = cap_results_q.pop_front();
               if (got.cap !== want.cap || got.unlimited !== want.unlimited ||
                   got.overflow !== want.overflow)
                  note_failure("result mismatch", want, got);
            end
         end

         // budget register
         if (csr_we)
            budget_q = csr_wdata;

         // demand word: store it, and on the last one predict the result
         if (req_tvalid && req_tready) begin
            d = req_tdata[DEMAND_WIDTH-1:0];
            if (held_count < MAX_ITEMS) begin
               demand_mem[held_count] = d;
               held_count++;
               held_total += 64'(d);
            end else begin
               store_full_hit = 1'b1;
            end
            if (req_tlast) begin
               if (held_total <= 64'(budget_q)) begin
                  want.cap       = '0;
                  want.unlimited = 1'b1;
               end else begin
                  want.cap       = largest_cap();
                  want.unlimited = 1'b0;
               end
               want.overflow = store_full_hit;
               cap_results_q = {cap_results_q, want};
               held_count     = 0;
               held_total     = '0;
               store_full_hit = 1'b0;
            end
         end
      end
      mismatches <= fail_count;
      awaiting   <= cap_results_q.size();
   end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// top of the budget cap search bench: clock, reset, demand stimulus, result stalls
// and the verdict; needs bcs_pkg, budget_cap_search_top and budget_cap_search_checker
module testbench;
   import bcs_pkg::*;

   localparam int          MAX_ITEMS       = 1024;
   localparam int          DEMAND_WIDTH    = 32;
   localparam int          DATA_W          = ((DEMAND_WIDTH + 7) / 8) * 8;
   localparam int          RESET_CYCLES    = 9;
   localparam int          RANDOM_PHASES   = 8;
   localparam int unsigned ITEMS_PER_PHASE = 12;
   localparam int unsigned LONG_HOLD       = 2500;
   localparam int unsigned PHASE_SETTLE    = 8;
   localparam int unsigned END_SETTLE      = 64;
   localparam longint unsigned CYCLE_LIMIT = 3_000_000;
   localparam logic [CAP_W-1:0] BUDGET_MAX = '1;

   typedef enum logic [1:0] {DEM_WIDE, DEM_NARROW, DEM_EDGE} demand_style_type;
   typedef enum logic [1:0] {
      STALL_NONE, STALL_ALTERNATE, STALL_LIGHT, STALL_HEAVY
   } stall_mode_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [DATA_W-1:0]  req_tdata = '0;   // demand
   logic               req_tlast = 1'b0; // last_item
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [CAP_W-1:0]   rsp_tdata;        // cap
   logic [1:0]         rsp_tuser;        // unlimited, overflow
   logic               csr_we = 1'b0;
   logic [CAP_W-1:0]   csr_wdata = '0;   // budget

   int unsigned        mismatches;
   int unsigned        awaiting;
   longint unsigned    cycle_count = 0;
   int unsigned        burst_left = 0;

   // receiver state
   stall_mode_type     stall_mode = STALL_NONE;
   int unsigned        stall_span = 0;
   int unsigned        hold_left = 0;
   logic               hold_request = 1'b0;
   logic               hold_taken = 1'b0;
   logic               alt_phase = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   budget_cap_search_top #(
      .MAX_ITEMS   (MAX_ITEMS),
      .DEMAND_WIDTH(DEMAND_WIDTH)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   budget_cap_search_checker #(
      .MAX_ITEMS   (MAX_ITEMS),
      .DEMAND_WIDTH(DEMAND_WIDTH)
   ) u_checker (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .mismatches(mismatches),
      .awaiting  (awaiting)
   );

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("budget_cap_search_top regression: fail");
         $finish;
      end
   end

   // result side: one long hold on request, otherwise a changing stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_request && !hold_taken) begin
         rsp_tready <= 1'b0;
         hold_taken <= 1'b1;
         hold_left  <= LONG_HOLD - 1;
      end else begin
         if (stall_span == 0) begin
            stall_mode <= stall_mode_type'($urandom_range(0, 3));
            stall_span <= $urandom_range(16, 400);
         end else begin
            stall_span <= stall_span - 1;
         end
         alt_phase <= !alt_phase;
         case (stall_mode)
            STALL_NONE:      rsp_tready <= 1'b1;
            STALL_ALTERNATE: rsp_tready <= alt_phase;
            STALL_LIGHT:     rsp_tready <= ($urandom_range(0, 3) != 0);
            default:         rsp_tready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   function automatic logic [CAP_W-1:0] rand48();
      logic [63:0] r;
      r = {$urandom(), $urandom()};
      return r[CAP_W-1:0];
   endfunction

   function automatic logic [DEMAND_WIDTH-1:0] pick_demand(input demand_style_type style);
      case (style)
         DEM_NARROW: return DEMAND_WIDTH'($urandom_range(0, 255));
         DEM_EDGE: begin
            case ($urandom_range(0, 4))
               0:       return '0;
               1:       return DEMAND_WIDTH'(1);
               2:       return '1;
               3:       return {{(DEMAND_WIDTH-1){1'b1}}, 1'b0};
               default: return DEMAND_WIDTH'($urandom());
            endcase
         end
         default: return DEMAND_WIDTH'($urandom());
      endcase
   endfunction

   // budget near the typical set total, so both outcomes show up
   function automatic logic [CAP_W-1:0] budget_for(input demand_style_type style);
      if ($urandom_range(0, 5) == 0)
         return rand48();
      case (style)
         DEM_NARROW: return CAP_W'($urandom_range(0, 3000));
         DEM_EDGE:   return rand48() >> $urandom_range(12, 20);
         default:    return rand48() >> $urandom_range(12, 17);
      endcase
   endfunction

   // offer one demand word, then idle between bursts
   task automatic send_word(input logic [DEMAND_WIDTH-1:0] value, input logic is_last);
      int unsigned gap;
      req_tvalid <= 1'b1;
      req_tdata  <= DATA_W'(value);
      req_tlast  <= is_last;
      do @(posedge clock); while (!req_tready);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(0, 12);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_set(input int unsigned count, input demand_style_type style);
      for (int unsigned i = 0; i < count; i++)
         send_word(pick_demand(style), i == count - 1);
   endtask

   // stop offering and wait for every pending result
   task automatic drain(input int unsigned settle);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (awaiting != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_budget(input logic [CAP_W-1:0] value);
      drain(PHASE_SETTLE);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      demand_style_type style;
      logic [CAP_W-1:0] budget;
      int unsigned      phase_items;
      int unsigned      set_len;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // small budget: fits, fits exactly, search, zero demand, huge demands
      write_budget(48'd10);
      send_word(32'd3, 1'b0);
      send_word(32'd4, 1'b0);
      send_word(32'd2, 1'b1);
      send_word(32'd3, 1'b0);
      send_word(32'd4, 1'b0);
      send_word(32'd3, 1'b1);
      send_word(32'd10, 1'b0);
      send_word(32'd1, 1'b1);
      send_word(32'd0, 1'b1);
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b1);
      send_word(32'd11, 1'b1);

      // zero budget: only an all-zero set fits
      write_budget('0);
      send_word(32'd0, 1'b0);
      send_word(32'd0, 1'b1);
      send_word(32'd1, 1'b1);

      // full budget: everything fits
      write_budget(BUDGET_MAX);
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b1);

      // cap lands at half the demand range
      write_budget(48'h0000_8000_0000);
      send_word(32'hFFFF_FFFF, 1'b1);

      // random sets, one budget per phase, extremes first and last
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         style = demand_style_type'($urandom_range(0, 2));
         if (phase == 0)
            budget = '0;
         else if (phase == RANDOM_PHASES - 1)
            budget = BUDGET_MAX;
         else
            budget = budget_for(style);
         write_budget(budget);
         if (phase == 2)
            hold_request <= 1'b1;
         phase_items = 0;
         while (phase_items < ITEMS_PER_PHASE) begin
            set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                  : $urandom_range(1, 8);
            send_set(set_len, style);
            phase_items += set_len;
            if (phase != 2 && $urandom_range(0, 11) == 0)
               drain(0);
         end
      end

      // more words than the store holds
      write_budget(rand48() >> $urandom_range(6, 9));
      send_set(MAX_ITEMS + $urandom_range(1, 6), DEM_WIDE);

      drain(END_SETTLE);
      if (mismatches == 0 && awaiting == 0)
         $display("budget_cap_search_top regression: pass");
      else
         $display("budget_cap_search_top regression: fail");
      $finish;
   end

endmodule
